FILE: src/assert_macros.svh
// Assertion macros shared by the list manager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define DLL_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Checks that a condition is followed in the next cycle by a consequence.
`define DLL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/dll_pkg.sv
// Package with the constants, codes and memory port types of the list manager.
`timescale 1ns / 1ps

package dll_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LINK_W     = $clog2(CAPACITY + 1);
   localparam int LEN_W      = $clog2(CAPACITY + 1);

   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

   typedef enum logic [1:0] {
      KIND_INS_HEAD = 2'd0,
      KIND_INS_TAIL = 2'd1,
      KIND_DELETE   = 2'd2,
      KIND_TRAVERSE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      logic                  ren;
      logic [IDX_W-1:0]      raddr;
      logic                  val_we;
      logic [IDX_W-1:0]      val_waddr;
      logic [DATA_WIDTH-1:0] val_wdata;
      logic                  nxt_we;
      logic [IDX_W-1:0]      nxt_waddr;
      logic [LINK_W-1:0]     nxt_wdata;
      logic                  prv_we;
      logic [IDX_W-1:0]      prv_waddr;
      logic [LINK_W-1:0]     prv_wdata;
   } mem_cmd_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] value;
      logic [LINK_W-1:0]     next;
      logic [LINK_W-1:0]     prev;
   } mem_rd_type;

endpackage

FILE: src/dll_store.sv
// Node store: value, forward link and backward link memories with one read port.
`timescale 1ns / 1ps

module dll_store
   import dll_pkg::*;
(
   input  logic        clock,
   input  mem_cmd_type cmd,
   output mem_rd_type  rd
);

   logic [DATA_WIDTH-1:0] value_mem [CAPACITY];
   logic [LINK_W-1:0]     next_mem  [CAPACITY];
   logic [LINK_W-1:0]     prev_mem  [CAPACITY];
   mem_rd_type            rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.val_we) begin
         value_mem[cmd.val_waddr] <= cmd.val_wdata;
      end
      if (cmd.nxt_we) begin
         next_mem[cmd.nxt_waddr] <= cmd.nxt_wdata;
      end
      if (cmd.prv_we) begin
         prev_mem[cmd.prv_waddr] <= cmd.prv_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ren) begin
         rd_ff.value <= value_mem[cmd.raddr];
         rd_ff.next  <= next_mem[cmd.raddr];
         rd_ff.prev  <= prev_mem[cmd.raddr];
      end
   end

   assign rd = rd_ff;

endmodule

FILE: src/dll_ctrl.sv
// Sequencer that walks, links and unlinks nodes and registers the results.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dll_ctrl
   import dll_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_kind,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic signed [DATA_WIDTH-1:0] rsp_item_value,
   output logic                         rsp_last,
   output logic [LEN_W-1:0]             rsp_length,
   output mem_cmd_type                  mem_cmd,
   input  mem_rd_type                   mem_rd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_LINK,
      S_WALK,
      S_UNLINK,
      S_TRAV,
      S_RESP
   } state_type;

   state_type             state_ff, state_in;
   kind_type              kind_ff, kind_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [IDX_W-1:0]      new_ff, new_in;
   logic [IDX_W-1:0]      cur_ff, cur_in;
   status_type            status_ff, status_in;
   logic [LINK_W-1:0]     head_ff, head_in;
   logic [LINK_W-1:0]     tail_ff, tail_in;
   logic [LEN_W-1:0]      count_ff, count_in;
   logic [CAPACITY-1:0]   used_ff, used_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [LEN_W-1:0]      rsp_length_ff, rsp_length_in;

   logic [IDX_W-1:0]      free_idx;
   logic                  out_free;
   logic                  rd_at_end;
   logic [LINK_W-1:0]     new_link;

   always_comb begin
      free_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rd_at_end = (mem_rd.next == NULL_LINK);
   assign new_link  = LINK_W'(new_ff);

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      value_in      = value_ff;
      new_in        = new_ff;
      cur_in        = cur_ff;
      status_in     = status_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_length_in = rsp_length_ff;
      mem_cmd       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in  = kind_type'(req_kind);
               value_in = req_value;
               new_in   = free_idx;
               cur_in   = head_ff[IDX_W-1:0];
               case (kind_type'(req_kind))
                  KIND_INS_HEAD, KIND_INS_TAIL: begin
                     if (count_ff == LEN_W'(CAPACITY)) begin
                        status_in = STATUS_FULL;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_INSERT;
                     end
                  end
                  KIND_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_NOT_FOUND;
                        state_in  = S_RESP;
                     end else begin
                        mem_cmd.ren   = 1'b1;
                        mem_cmd.raddr = head_ff[IDX_W-1:0];
                        state_in      = S_WALK;
                     end
                  end
                  KIND_TRAVERSE: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                        state_in  = S_RESP;
                     end else begin
                        mem_cmd.ren   = 1'b1;
                        mem_cmd.raddr = head_ff[IDX_W-1:0];
                        state_in      = S_TRAV;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_INSERT: begin
            mem_cmd.val_we    = 1'b1;
            mem_cmd.val_waddr = new_ff;
            mem_cmd.val_wdata = value_ff;
            mem_cmd.nxt_we    = 1'b1;
            mem_cmd.nxt_waddr = new_ff;
            mem_cmd.nxt_wdata = NULL_LINK;
            mem_cmd.prv_we    = 1'b1;
            mem_cmd.prv_waddr = new_ff;
            mem_cmd.prv_wdata = NULL_LINK;
            used_in[new_ff]   = 1'b1;
            count_in          = count_ff + 1'b1;
            status_in         = STATUS_OK;
            if (count_ff == '0) begin
               head_in  = new_link;
               tail_in  = new_link;
               state_in = S_RESP;
            end else begin
               if (kind_ff == KIND_INS_HEAD) begin
                  mem_cmd.nxt_wdata = head_ff;
               end else begin
                  mem_cmd.prv_wdata = tail_ff;
               end
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            if (kind_ff == KIND_INS_HEAD) begin
               mem_cmd.prv_we    = 1'b1;
               mem_cmd.prv_waddr = head_ff[IDX_W-1:0];
               mem_cmd.prv_wdata = new_link;
               head_in           = new_link;
            end else begin
               mem_cmd.nxt_we    = 1'b1;
               mem_cmd.nxt_waddr = tail_ff[IDX_W-1:0];
               mem_cmd.nxt_wdata = new_link;
               tail_in           = new_link;
            end
            state_in = S_RESP;
         end
         S_WALK: begin
            if (mem_rd.value == value_ff) begin
               state_in = S_UNLINK;
            end else if (rd_at_end) begin
               status_in = STATUS_NOT_FOUND;
               state_in  = S_RESP;
            end else begin
               mem_cmd.ren   = 1'b1;
               mem_cmd.raddr = mem_rd.next[IDX_W-1:0];
               cur_in        = mem_rd.next[IDX_W-1:0];
            end
         end
         S_UNLINK: begin
            if (LINK_W'(cur_ff) == head_ff) begin
               head_in = mem_rd.next;
            end
            if (LINK_W'(cur_ff) == tail_ff) begin
               tail_in = mem_rd.prev;
            end
            if (mem_rd.prev != NULL_LINK) begin
               mem_cmd.nxt_we    = 1'b1;
               mem_cmd.nxt_waddr = mem_rd.prev[IDX_W-1:0];
               mem_cmd.nxt_wdata = mem_rd.next;
            end
            if (mem_rd.next != NULL_LINK) begin
               mem_cmd.prv_we    = 1'b1;
               mem_cmd.prv_waddr = mem_rd.next[IDX_W-1:0];
               mem_cmd.prv_wdata = mem_rd.prev;
            end
            used_in[cur_ff] = 1'b0;
            count_in        = count_ff - 1'b1;
            status_in       = STATUS_OK;
            state_in        = S_RESP;
         end
         S_TRAV: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_value_in  = mem_rd.value;
               rsp_last_in   = rd_at_end;
               rsp_length_in = count_ff;
               if (rd_at_end) begin
                  state_in = S_IDLE;
               end else begin
                  mem_cmd.ren   = 1'b1;
                  mem_cmd.raddr = mem_rd.next[IDX_W-1:0];
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
               rsp_length_in = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NULL_LINK;
         tail_ff      <= NULL_LINK;
         count_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      new_ff        <= new_in;
      cur_ff        <= cur_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_item_value = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_length     = rsp_length_ff;

   `DLL_ASSERT(a_count_matches_used, $countones(used_ff) == count_ff, "node count differs from used nodes")
   `DLL_ASSERT(a_head_null_when_empty, (count_ff == '0) == (head_ff == NULL_LINK), "head and count disagree")
   `DLL_ASSERT_NEXT(a_insert_grows, state_ff == S_INSERT, count_ff == $past(count_ff) + 1'b1, "insert did not grow the list")
   `DLL_ASSERT_NEXT(a_unlink_shrinks, state_ff == S_UNLINK, count_ff == $past(count_ff) - 1'b1, "delete did not shrink the list")

endmodule

FILE: src/doubly_linked_list_manager.sv
// Insert writes the node in S_INSERT, links its neighbour in S_LINK unless the list was empty
// and answers from S_RESP. Delete walks from the head in S_WALK, unlinks in S_UNLINK and
// answers from S_RESP. Traverse gives one result per cycle unless rsp_stall holds the output.
// One transaction at a time; the walk follows one link per cycle through the single read port.
// Reset clears the list to empty at once; the node memories need no clearing.
`timescale 1ns / 1ps

module doubly_linked_list_manager
   import dll_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_kind,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic signed [DATA_WIDTH-1:0] rsp_item_value,
   output logic                         rsp_last,
   output logic [LEN_W-1:0]             rsp_length
);

   mem_cmd_type mem_cmd;
   mem_rd_type  mem_rd;

   dll_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_item_value (rsp_item_value),
      .rsp_last       (rsp_last),
      .rsp_length     (rsp_length),
      .mem_cmd        (mem_cmd),
      .mem_rd         (mem_rd)
   );

   dll_store u_store (
      .clock (clock),
      .cmd   (mem_cmd),
      .rd    (mem_rd)
   );

endmodule
